// ===== hdl/stc_pkg.sv =====
package stc_pkg;

    // token kinds
    localparam logic [4:0] KIND_IDENT    = 5'd0;
    localparam logic [4:0] KIND_NUMBER   = 5'd1;
    localparam logic [4:0] KIND_EQ_GT    = 5'd2;
    localparam logic [4:0] KIND_EQ_PLUS  = 5'd3;
    localparam logic [4:0] KIND_EQ_MINUS = 5'd4;
    localparam logic [4:0] KIND_EQ_STAR  = 5'd5;
    localparam logic [4:0] KIND_EQ_SLASH = 5'd6;
    localparam logic [4:0] KIND_EQ_PCT   = 5'd7;
    localparam logic [4:0] KIND_EQ_EQ    = 5'd8;
    localparam logic [4:0] KIND_EQUAL    = 5'd9;
    localparam logic [4:0] KIND_LPAREN   = 5'd10;
    localparam logic [4:0] KIND_RPAREN   = 5'd11;
    localparam logic [4:0] KIND_LBRACE   = 5'd12;
    localparam logic [4:0] KIND_RBRACE   = 5'd13;
    localparam logic [4:0] KIND_COLON    = 5'd14;
    localparam logic [4:0] KIND_COMMA    = 5'd15;
    localparam logic [4:0] KIND_PLUS     = 5'd16;
    localparam logic [4:0] KIND_STAR     = 5'd17;
    localparam logic [4:0] KIND_EOF      = 5'd18;
    localparam logic [4:0] KIND_ERROR    = 5'd19;
    localparam logic [4:0] KIND_NONE     = 5'd0;

    // characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EQ  = 8'h3d;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       first;
        logic       last;
    } token_t;

    // words produced by one classifier step
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               c == 8'h5f || c == 8'h26 || c == 8'h24;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_CR || c == CH_LF || c == CH_SP || c == CH_TAB;
    endfunction

    // kind of '=' followed by c, KIND_NONE when no pair
    function automatic logic [4:0] pair_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3e:   k = KIND_EQ_GT;
            8'h2b:   k = KIND_EQ_PLUS;
            8'h2d:   k = KIND_EQ_MINUS;
            8'h2a:   k = KIND_EQ_STAR;
            8'h2f:   k = KIND_EQ_SLASH;
            8'h25:   k = KIND_EQ_PCT;
            8'h3d:   k = KIND_EQ_EQ;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of single punctuation, KIND_NONE when not punctuation
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h3a:   k = KIND_COLON;
            8'h2c:   k = KIND_COMMA;
            8'h2b:   k = KIND_PLUS;
            8'h2a:   k = KIND_STAR;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/script_token_classifier_unit.sv =====
// a token byte is held back until the next byte is classified, so its last
// flag is exact; throughput: one byte per cycle while the queue has two
// free slots; a NUL or bad byte that closes a held token makes two words,
// drained by the 4-entry result queue at one word per cycle unless stalled
// reset: asynchronous active low, clears held token, halt flag and queue
module script_token_classifier_unit (
    input  logic       clk,
    input  logic       rst_n,
    // input byte channel
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] in_char,
    // token word channel
    output logic       token_valid,
    input  logic       token_stall,
    output logic [4:0] token_kind,
    output logic [7:0] token_char,
    output logic       token_first,
    output logic       token_last
);
    import stc_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_char_reg, in_char_next;
    logic             accept;
    logic             step;
    logic             pop;
    logic             not_empty;
    logic [CNT_W-1:0] level;
    logic [CNT_W-1:0] level_after_pop;
    push_t            push;
    token_t           head;

    // a step may push two words, so require two free slots after this pop
    always_comb
    begin
        pop             = not_empty && !token_stall;
        level_after_pop = level - CNT_W'(pop);
        step            = in_valid_reg &&
                          (level_after_pop <= CNT_W'(FIFO_DEPTH - 2));
        char_stall      = in_valid_reg && !step;
        accept          = char_valid && !char_stall;

        in_char_next  = accept ? in_char : in_char_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
    end

    // classifier with the held token and halt flag
    stc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .c     (in_char_reg),
        .push  (push)
    );

    // result queue, also the output register
    stc_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (not_empty),
        .level     (level),
        .head      (head)
    );

    assign token_valid = not_empty;
    assign token_kind  = head.kind;
    assign token_char  = head.ch;
    assign token_first = head.first;
    assign token_last  = head.last;

endmodule

// ===== hdl/stc_core.sv =====
module stc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     c,
    output stc_pkg::push_t push
);
    import stc_pkg::*;

    logic [7:0] held_char_reg, held_char_next;
    logic [4:0] held_kind_reg, held_kind_next;
    logic       held_first_reg, held_first_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_closed_reg, held_closed_next;
    logic       halted_reg, halted_next;

    logic [4:0] pk;
    logic [4:0] uk;
    logic       open_held;
    logic       new_out;
    token_t     flush_tok;
    token_t     new_tok;

    always_comb
    begin
        pk = pair_kind(c);
        uk = punct_kind(c);
        open_held = held_valid_reg && !held_closed_reg;

        held_char_next   = held_char_reg;
        held_kind_next   = held_kind_reg;
        held_first_next  = held_first_reg;
        held_valid_next  = held_valid_reg;
        held_closed_next = held_closed_reg;
        halted_next      = halted_reg;

        flush_tok = '{kind: held_kind_reg, ch: held_char_reg,
                      first: held_first_reg, last: 1'b1};
        new_tok   = '{kind: KIND_EOF, ch: CH_NUL, first: 1'b1, last: 1'b1};
        new_out   = 1'b0;
        push      = '0;

        if (halted_reg)
        begin
            push.count = 2'd0;
        end
        else if (open_held && held_kind_reg == KIND_EQUAL && pk != KIND_NONE)
        begin
            // operator pair: report '=' with pair kind, hold second byte closed
            push.count = 2'd1;
            push.tok0  = '{kind: pk, ch: held_char_reg,
                           first: held_first_reg, last: 1'b0};
            held_char_next   = c;
            held_kind_next   = pk;
            held_first_next  = 1'b0;
            held_closed_next = 1'b1;
        end
        else if (open_held && ((held_kind_reg == KIND_IDENT && is_ident(c)) ||
                               (held_kind_reg == KIND_NUMBER && is_digit(c))))
        begin
            // run continues
            push.count = 2'd1;
            push.tok0  = '{kind: held_kind_reg, ch: held_char_reg,
                           first: held_first_reg, last: 1'b0};
            held_char_next   = c;
            held_first_next  = 1'b0;
            held_closed_next = 1'b0;
        end
        else
        begin
            // held token ends here
            held_valid_next  = 1'b0;
            held_closed_next = 1'b0;

            if (is_space(c))
            begin
                new_out = 1'b0;
            end
            else if (c == CH_NUL)
            begin
                new_out = 1'b1;
            end
            else if (is_ident(c) || is_digit(c) || c == CH_EQ || uk != KIND_NONE)
            begin
                held_char_next   = c;
                held_first_next  = 1'b1;
                held_valid_next  = 1'b1;
                if (is_ident(c))
                begin
                    held_kind_next   = KIND_IDENT;
                    held_closed_next = 1'b0;
                end
                else if (is_digit(c))
                begin
                    held_kind_next   = KIND_NUMBER;
                    held_closed_next = 1'b0;
                end
                else if (c == CH_EQ)
                begin
                    held_kind_next   = KIND_EQUAL;
                    held_closed_next = 1'b0;
                end
                else
                begin
                    held_kind_next   = uk;
                    held_closed_next = 1'b1;
                end
            end
            else
            begin
                new_out     = 1'b1;
                new_tok     = '{kind: KIND_ERROR, ch: c, first: 1'b1, last: 1'b1};
                halted_next = 1'b1;
            end

            if (held_valid_reg)
            begin
                push.tok0  = flush_tok;
                push.tok1  = new_tok;
                push.count = new_out ? 2'd2 : 2'd1;
            end
            else
            begin
                push.tok0  = new_tok;
                push.count = new_out ? 2'd1 : 2'd0;
            end
        end

        if (!step)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg   <= '0;
            held_kind_reg   <= '0;
            held_first_reg  <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_closed_reg <= 1'b0;
            halted_reg      <= 1'b0;
        end
        else if (step)
        begin
            held_char_reg   <= held_char_next;
            held_kind_reg   <= held_kind_next;
            held_first_reg  <= held_first_next;
            held_valid_reg  <= held_valid_next;
            held_closed_reg <= held_closed_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

// ===== hdl/stc_out_fifo.sv =====
module stc_out_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  stc_pkg::push_t            push,
    input  logic                      pop,
    output logic                      not_empty,
    output logic [stc_pkg::CNT_W-1:0] level,
    output stc_pkg::token_t           head
);
    import stc_pkg::*;

    token_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   wp_plus1;

    always_comb
    begin
        wp_plus1  = wp_reg + PTR_W'(1);
        wp_next   = wp_reg + PTR_W'(push.count);
        rp_next   = pop ? rp_reg + PTR_W'(1) : rp_reg;
        cnt_next  = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
        not_empty = cnt_reg != '0;
        level     = cnt_reg;
        head      = mem_reg[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wp_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wp_plus1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
